[hdl/number_to_ascii_formatter_assert.svh]
// assertion macros for the number to ascii formatter checker
// depends on nothing; included by files that hold concurrent assertions
`ifndef NUMBER_TO_ASCII_FORMATTER_ASSERT_SVH
`define NUMBER_TO_ASCII_FORMATTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define NTAF_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define NTAF_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/ntaf_pkg.sv]
// shared types and constants of the number to ascii formatter
// depends on nothing
package ntaf_pkg;

  localparam logic [1:0] CMD_DEC = 2'd0;
  localparam logic [1:0] CMD_HEX = 2'd1;
  localparam logic [1:0] CMD_IP  = 2'd2;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_DOT  = 8'h2e;
  localparam logic [7:0] CHAR_A    = 8'h61;

  // digit position 0 is the ten-thousands place, 4 the units place
  localparam logic [2:0] POS_LAST = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [31:0]      value;
    logic [3:0][2:0]  start;
  } entry_t;

endpackage

[hdl/ntaf_front.sv]
// front part: accepts beats, drops unused commands, finds first digit positions
// depends on ntaf_pkg
module ntaf_front
  import ntaf_pkg::*;
(
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t in_beat,
  output logic     push_valid,
  input  logic     push_stall,
  output entry_t   push_entry
);

  function automatic logic [2:0] byte_start(input logic [7:0] b);
    logic [2:0] p;
    if (b >= 8'd100) begin
      p = 3'd2;
    end else if (b >= 8'd10) begin
      p = 3'd3;
    end else begin
      p = POS_LAST;
    end
    return p;
  endfunction

  function automatic logic [2:0] word_start(input logic [15:0] w);
    logic [2:0] p;
    if (w >= 16'd10000) begin
      p = 3'd0;
    end else if (w >= 16'd1000) begin
      p = 3'd1;
    end else if (w >= 16'd100) begin
      p = 3'd2;
    end else if (w >= 16'd10) begin
      p = 3'd3;
    end else begin
      p = POS_LAST;
    end
    return p;
  endfunction

  logic known_cmd;

  assign known_cmd = (in_beat.command == CMD_DEC) || (in_beat.command == CMD_HEX) ||
                     (in_beat.command == CMD_IP);
  assign in_stall   = push_stall;
  assign push_valid = in_valid && known_cmd;

  always_comb begin
    push_entry.command  = in_beat.command;
    push_entry.value    = in_beat.value;
    push_entry.start[1] = byte_start(in_beat.value[23:16]);
    push_entry.start[2] = byte_start(in_beat.value[15:8]);
    push_entry.start[3] = byte_start(in_beat.value[7:0]);
    if (in_beat.command == CMD_DEC) begin
      push_entry.start[0] = word_start(in_beat.value[15:0]);
    end else begin
      push_entry.start[0] = byte_start(in_beat.value[31:24]);
    end
  end

endmodule

[hdl/ntaf_queue.sv]
// short queue between the front and back parts
// depends on ntaf_pkg
module ntaf_queue
  import ntaf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_stall,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_stall,
  output entry_t pop_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_stall = (count == CNT_MAX);
  assign pop_valid  = (count != '0);
  assign pop_entry  = mem[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/ntaf_back.sv]
// back part: emits one character per cycle, while busy and the output is not stalled, into the output register
// depends on ntaf_pkg
module ntaf_back
  import ntaf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  output logic      pop_stall,
  input  entry_t    pop_entry,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  localparam logic [1:0] KIND_DIGIT = 2'd0;
  localparam logic [1:0] KIND_DOT   = 2'd1;
  localparam logic [1:0] KIND_HEX   = 2'd2;

  function automatic logic [16:0] weight_mult(input logic [2:0] p, input logic [3:0] k);
    logic [13:0] w;
    unique case (p)
      3'd0:    w = 14'd10000;
      3'd1:    w = 14'd1000;
      3'd2:    w = 14'd100;
      3'd3:    w = 14'd10;
      default: w = 14'd1;
    endcase
    return 17'(w) * 17'(k);
  endfunction

  logic            busy;
  logic [1:0]      kind;
  logic [1:0]      command;
  logic [31:0]     value;
  logic [3:0][2:0] start;
  logic [15:0]     rest;
  logic [2:0]      pos;
  logic [1:0]      idx;

  logic            adv;
  logic            fin;
  logic            load;
  logic [3:0]      digit;
  logic [16:0]     sub;
  logic [1:0]      idx_next;
  logic [3:0]      nib;
  logic [7:0]      char_next;
  logic [7:0]      byte_next;
  logic [7:0]      first_byte;

  assign adv       = busy && (!out_valid || !out_stall);
  assign pop_stall = !(!busy || (adv && fin));
  assign load      = pop_valid && !pop_stall;
  assign idx_next  = idx + 2'd1;
  assign byte_next = value[{~idx_next, 3'b000} +: 8];
  assign first_byte = pop_entry.value[31:24];
  assign nib       = pos[0] ? value[3:0] : value[7:4];

  always_comb begin
    digit = '0;
    sub   = '0;
    for (int k = 1; k < 10; k++) begin
      if ({1'b0, rest} >= weight_mult(pos, 4'(k))) begin
        digit = 4'(k);
        sub   = weight_mult(pos, 4'(k));
      end
    end
  end

  always_comb begin
    fin       = 1'b0;
    char_next = CHAR_DOT;
    unique case (kind)
      KIND_DIGIT: begin
        char_next = CHAR_ZERO + {4'd0, digit};
        fin = (pos == POS_LAST) && ((command == CMD_DEC) || (idx == 2'd3));
      end
      KIND_DOT: begin
        char_next = CHAR_DOT;
      end
      KIND_HEX: begin
        char_next = (nib < 4'd10) ? CHAR_ZERO + {4'd0, nib} : CHAR_A + {4'd0, nib - 4'd10};
        fin = pos[0];
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (adv && fin) begin
        busy <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_beat.character <= char_next;
      out_beat.last      <= fin;
    end
    if (load) begin
      command <= pop_entry.command;
      value   <= pop_entry.value;
      start   <= pop_entry.start;
      idx     <= '0;
      if (pop_entry.command == CMD_HEX) begin
        kind <= KIND_HEX;
        pos  <= '0;
      end else begin
        kind <= KIND_DIGIT;
        pos  <= pop_entry.start[0];
        rest <= (pop_entry.command == CMD_DEC) ? pop_entry.value[15:0] : {8'd0, first_byte};
      end
    end else if (adv) begin
      unique case (kind)
        KIND_DIGIT: begin
          rest <= 16'(({1'b0, rest}) - sub);
          if (pos == POS_LAST) begin
            kind <= KIND_DOT;
          end else begin
            pos <= pos + 3'd1;
          end
        end
        KIND_DOT: begin
          kind <= KIND_DIGIT;
          idx  <= idx_next;
          rest <= {8'd0, byte_next};
          pos  <= start[idx_next];
        end
        KIND_HEX: begin
          pos <= 3'd1;
        end
        default: begin
          kind <= KIND_DIGIT;
        end
      endcase
    end
  end

endmodule

[hdl/number_to_ascii_formatter.sv]
// the first character of a beat passes through the queue, the back part's registers
// and the output register; one character per cycle while the output is not stalled;
// an item gives 1 to 15 characters, with no gap between items; command 3 gives no beat
// the queue lets the front keep taking beats while the output is stalled
// reset clears the queue, the back part and the output valid
module number_to_ascii_formatter
  import ntaf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  logic   push_valid;
  logic   push_stall;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_stall;
  entry_t pop_entry;

  ntaf_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .push_valid(push_valid),
    .push_stall(push_stall),
    .push_entry(push_entry)
  );

  ntaf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_stall(push_stall),
    .push_entry(push_entry),
    .pop_valid (pop_valid),
    .pop_stall (pop_stall),
    .pop_entry (pop_entry)
  );

  ntaf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_stall(pop_stall),
    .pop_entry(pop_entry),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

endmodule

[hdl/ntaf_checker.sv]
// port level checks of the number to ascii formatter, bound to the top level
// depends on ntaf_pkg and number_to_ascii_formatter_assert.svh
`include "number_to_ascii_formatter_assert.svh"

module ntaf_checker
  import ntaf_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_beat
);

  logic char_ok;

  assign char_ok = ((out_beat.character >= CHAR_ZERO) &&
                    (out_beat.character <= CHAR_ZERO + 8'd9)) ||
                   ((out_beat.character >= CHAR_A) && (out_beat.character <= CHAR_A + 8'd5)) ||
                   (out_beat.character == CHAR_DOT);

  // stalled beat stays
  `NTAF_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_beat))
  // only digits, hex letters and dots appear
  `NTAF_ASSERT_IMP(a_char_set, clk, rst, out_valid, char_ok)
  // a dot never ends a run
  `NTAF_ASSERT_IMP(a_dot_not_last, clk, rst, out_valid && (out_beat.character == CHAR_DOT),
                   !out_beat.last)
  // nothing comes out in the cycle after reset
  `NTAF_ASSERT_IMP(a_reset_quiet, clk, rst, $past(rst), !out_valid)

endmodule

bind number_to_ascii_formatter ntaf_checker u_ntaf_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_beat (out_beat)
);
